// ===== hw/rtl/b2sbcd_pkg.sv =====
`timescale 1ns / 1ps

package b2sbcd_pkg;

	localparam int unsigned MAG_W    = 32;
	localparam int unsigned NIBBLES  = 10;
	localparam int unsigned BCD_W    = 4 * NIBBLES;
	localparam int unsigned CNT_W    = 5;
	localparam int unsigned LEN_W    = 3;

	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAG_W - 1);
	localparam logic [3:0]       SIGN_NEG  = 4'hD;
	localparam logic [3:0]       SIGN_POS  = 4'h0;

	localparam logic REG_SIGNED_MODE  = 1'b0;
	localparam logic REG_LENGTH_BYTES = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} dabble_ctrl_t;

endpackage

// ===== hw/rtl/b2sbcd_dabble.sv =====
`timescale 1ns / 1ps

module b2sbcd_dabble (
	input  logic                          clk,
	input  b2sbcd_pkg::dabble_ctrl_t      ctrl,
	input  logic [b2sbcd_pkg::MAG_W-1:0]  mag,
	output logic [b2sbcd_pkg::BCD_W-1:0]  bcd
);

	logic [b2sbcd_pkg::MAG_W-1:0] bin_q;
	logic [b2sbcd_pkg::BCD_W-1:0] bcd_q;
	logic [b2sbcd_pkg::BCD_W-1:0] adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < b2sbcd_pkg::NIBBLES; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (ctrl.step) begin
			bcd_q <= {adj[b2sbcd_pkg::BCD_W-2:0], bin_q[b2sbcd_pkg::MAG_W-1]};
			bin_q <= {bin_q[b2sbcd_pkg::MAG_W-2:0], 1'b0};
		end
	end

	assign bcd = bcd_q;

endmodule

// ===== hw/rtl/binary_to_signed_packed_bcd_core.sv =====
`timescale 1ns / 1ps

// Converts one signed 32-bit value per item into length_bytes packed BCD bytes, most
// significant byte first, with last set on the final byte. In signed mode the lowest
// nibble carries the sign (0x0 positive, 0xD negative) and the magnitude's digits fill
// the nibbles above; in unsigned mode all nibbles are digits of the magnitude. Digits
// that do not fit are dropped from the top. Each item is accepted, then converted by the
// add-3-and-shift digit unit one magnitude bit per step, then sent one byte per output
// handshake (1 to 5 bytes); value_ready is low until the last byte of the item has been
// taken. Registers: 0x0 signed_mode (reset 1), 0x4 length_bytes (reset 5; 0 acts as 1,
// values above MAX_BYTES act as MAX_BYTES).

module binary_to_signed_packed_bcd_core #(
	parameter int unsigned MAX_BYTES = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        value_valid,
	output logic        value_ready,
	input  logic signed [31:0] value,
	output logic        byte_valid,
	input  logic        byte_ready,
	output logic [7:0]  bcd_byte,
	output logic        last
);

	localparam int unsigned DW = 8 * MAX_BYTES;
	localparam logic [b2sbcd_pkg::LEN_W-1:0] MAX_LEN = b2sbcd_pkg::LEN_W'(MAX_BYTES);

	b2sbcd_pkg::state_t state_q, state_d;
	b2sbcd_pkg::dabble_ctrl_t ctrl;

	logic                             signed_mode_q;
	logic [b2sbcd_pkg::LEN_W-1:0]     length_q;
	logic [b2sbcd_pkg::CNT_W-1:0]     cnt_q;
	logic [b2sbcd_pkg::LEN_W-1:0]     bytes_left_q;
	logic [b2sbcd_pkg::LEN_W-1:0]     run_len;
	logic [b2sbcd_pkg::LEN_W-1:0]     byte_idx;
	logic                             neg_q;
	logic [DW-1:0]                    shifted;
	logic [b2sbcd_pkg::BCD_W-1:0]     bcd;
	logic [b2sbcd_pkg::BCD_W-1:0]     res;
	logic [b2sbcd_pkg::MAG_W-1:0]     mag;
	logic                             cfg_wr;
	logic                             in_acc;
	logic                             out_acc;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign in_acc  = value_valid && value_ready;
	assign out_acc = byte_valid && byte_ready;

	always_comb begin
		case (paddr[2])
			b2sbcd_pkg::REG_SIGNED_MODE:  prdata = {31'b0, signed_mode_q};
			b2sbcd_pkg::REG_LENGTH_BYTES: prdata = {29'b0, length_q};
			default:                      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b1;
			length_q      <= 3'd5;
		end else if (cfg_wr) begin
			case (paddr[2])
				b2sbcd_pkg::REG_SIGNED_MODE:  signed_mode_q <= pwdata[0];
				b2sbcd_pkg::REG_LENGTH_BYTES: length_q      <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (length_q == '0) begin
			run_len = b2sbcd_pkg::LEN_W'(1);
		end else if (length_q > MAX_LEN) begin
			run_len = MAX_LEN;
		end else begin
			run_len = length_q;
		end
	end

	assign mag = value[31] ? (32'd0 - value) : value;

	b2sbcd_dabble u_dabble (
		.clk  (clk),
		.ctrl (ctrl),
		.mag  (mag),
		.bcd  (bcd)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			b2sbcd_pkg::ST_IDLE: begin
				if (in_acc) state_d = b2sbcd_pkg::ST_CONV;
			end
			b2sbcd_pkg::ST_CONV: begin
				if (cnt_q == b2sbcd_pkg::LAST_STEP) state_d = b2sbcd_pkg::ST_OUT;
			end
			b2sbcd_pkg::ST_OUT: begin
				if (out_acc && last) state_d = b2sbcd_pkg::ST_IDLE;
			end
			default: state_d = b2sbcd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		value_ready = 1'b0;
		byte_valid  = 1'b0;
		ctrl.load   = 1'b0;
		ctrl.step   = 1'b0;
		case (state_q)
			b2sbcd_pkg::ST_IDLE: begin
				value_ready = 1'b1;
				ctrl.load   = value_valid;
			end
			b2sbcd_pkg::ST_CONV: ctrl.step  = 1'b1;
			b2sbcd_pkg::ST_OUT:  byte_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= b2sbcd_pkg::ST_IDLE;
			cnt_q        <= '0;
			bytes_left_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				cnt_q <= '0;
			end else if (state_q == b2sbcd_pkg::ST_CONV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == b2sbcd_pkg::ST_CONV && cnt_q == b2sbcd_pkg::LAST_STEP) begin
				bytes_left_q <= run_len;
			end else if (out_acc) begin
				bytes_left_q <= bytes_left_q - 1'b1;
			end
		end
	end

	// sign nibble takes the lowest place in signed mode
	assign res = signed_mode_q
		? {bcd[b2sbcd_pkg::BCD_W-5:0], (neg_q ? b2sbcd_pkg::SIGN_NEG : b2sbcd_pkg::SIGN_POS)}
		: bcd;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			neg_q <= value[31];
		end
	end

	// digit unit holds the finished digits for the whole output phase
	assign byte_idx = bytes_left_q - 1'b1;
	assign shifted  = res[DW-1:0] >> {byte_idx, 3'b000};
	assign bcd_byte = shifted[7:0];
	assign last     = (bytes_left_q == b2sbcd_pkg::LEN_W'(1));

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned MAX_BYTES = 5;
	localparam logic [2:0] ADDR_SIGNED_MODE  = {b2sbcd_pkg::REG_SIGNED_MODE, 2'b00};
	localparam logic [2:0] ADDR_LENGTH_BYTES = {b2sbcd_pkg::REG_LENGTH_BYTES, 2'b00};
	localparam int unsigned ITEMS_PER_SETTING = 56;

	typedef enum logic [1:0] {
		ROW_MODE,
		ROW_LEN,
		ROW_VALUE
	} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [31:0] data;
		bit          has_image;
		logic [39:0] image;
	} stim_row_t;

	typedef struct {
		logic [7:0] bcd_byte;
		logic       last;
	} bcd_out_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        value_valid;
	logic        value_ready;
	logic signed [31:0] value;
	logic        byte_valid;
	logic        byte_ready;
	logic [7:0]  bcd_byte;
	logic        last;

	bit          cfg_signed = 1'b1;
	logic [2:0]  cfg_len = 3'd5;
	bcd_out_t    pending_bytes[$];
	stim_row_t   dir_rows[$];
	int unsigned mismatch_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	binary_to_signed_packed_bcd_core #(
		.MAX_BYTES(MAX_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.value_valid(value_valid),
		.value_ready(value_ready),
		.value(value),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.bcd_byte(bcd_byte),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [39:0] bcd_image(logic [31:0] raw);
		logic [31:0] mag;
		logic [39:0] img;
		int unsigned pos;
		mag = raw[31] ? -raw : raw;
		img = '0;
		pos = 0;
		if (cfg_signed) begin
			img[3:0] = raw[31] ? b2sbcd_pkg::SIGN_NEG : b2sbcd_pkg::SIGN_POS;
			pos = 1;
		end
		while (pos < b2sbcd_pkg::NIBBLES) begin
			img[4*pos +: 4] = 4'(mag % 10);
			mag = mag / 10;
			pos++;
		end
		return img;
	endfunction

	function automatic int unsigned byte_count();
		int unsigned n;
		n = 32'(cfg_len);
		if (n == 0)
			n = 1;
		if (n > MAX_BYTES)
			n = MAX_BYTES;
		return n;
	endfunction

	function automatic void push_bytes(logic [39:0] img);
		bcd_out_t e;
		int unsigned n;
		n = byte_count();
		for (int unsigned k = 0; k < n; k++) begin
			e.bcd_byte = img[8*(n-1-k) +: 8];
			e.last = (k == n - 1);
			pending_bytes.push_back(e);
		end
	endfunction

	function automatic void add_row(row_kind_t kind, logic [31:0] data, bit has_image,
			logic [39:0] image);
		stim_row_t r;
		r.kind = kind;
		r.data = data;
		r.has_image = has_image;
		r.image = image;
		dir_rows.push_back(r);
	endfunction

	function automatic logic [31:0] rand_value();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, 99);
			1: v = -$urandom_range(0, 99);
			2: v = $urandom_range(0, 999999);
			3: v = -$urandom_range(0, 99999999);
			4: begin
				case ($urandom_range(0, 7))
					0: v = 32'h7fff_ffff;
					1: v = 32'h8000_0000;
					2: v = 32'h8000_0001;
					3: v = 32'hffff_ffff;
					4: v = 32'd0;
					5: v = 32'd999999999;
					6: v = 32'd1000000000;
					default: v = -32'd999999999;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
		$display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, exp);
		mismatch_count++;
	endtask

	// called at a falling edge, returns at a falling edge with the bus idle
	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == ADDR_SIGNED_MODE)
			cfg_signed = data[0];
		else
			cfg_len = data[2:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_value(logic [31:0] v, bit has_image, logic [39:0] image);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			value_valid <= 1'b0;
			@(negedge clk);
		end
		value_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (!value_ready)
			@(posedge clk);
		push_bytes(has_image ? image : bcd_image(v));
		@(negedge clk);
	endtask

	task automatic drain();
		value_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n)
			byte_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		bcd_out_t e;
		if (arst_n && byte_valid && byte_ready) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch("unexpected item, bcd_byte", 32'(bcd_byte), 32'd0);
			end else begin
				e = pending_bytes.pop_front();
				if (bcd_byte !== e.bcd_byte)
					report_mismatch("bcd_byte", 32'(bcd_byte), 32'(e.bcd_byte));
				if (last !== e.last)
					report_mismatch("last", 32'(last), 32'(e.last));
			end
		end
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int unsigned idle_plan[4];
		int unsigned stall_plan[4];
		idle_plan = '{0, 75, 0, 22};
		stall_plan = '{0, 0, 75, 22};
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		value_valid = 1'b0;
		value = '0;
		byte_ready = 1'b0;

		// reset settings: signed, five bytes
		add_row(ROW_VALUE, 32'd0, 1'b1, 40'h00_0000_0000);
		add_row(ROW_VALUE, 32'd1, 1'b1, 40'h00_0000_0010);
		add_row(ROW_VALUE, 32'hffff_ffff, 1'b1, 40'h00_0000_001d);
		add_row(ROW_VALUE, 32'h7fff_ffff, 1'b1, 40'h14_7483_6470);
		add_row(ROW_VALUE, 32'h8000_0000, 1'b1, 40'h14_7483_648d);
		add_row(ROW_VALUE, 32'd12345, 1'b1, 40'h00_0012_3450);
		add_row(ROW_MODE, 32'd0, 1'b0, '0);
		add_row(ROW_VALUE, 32'h7fff_ffff, 1'b1, 40'h21_4748_3647);
		add_row(ROW_VALUE, 32'h8000_0000, 1'b1, 40'h21_4748_3648);
		add_row(ROW_VALUE, 32'hffff_ffff, 1'b1, 40'h00_0000_0001);
		add_row(ROW_VALUE, 32'd0, 1'b1, 40'h00_0000_0000);
		add_row(ROW_LEN, 32'd1, 1'b0, '0);
		add_row(ROW_VALUE, 32'd98, 1'b1, 40'h00_0000_0098);
		add_row(ROW_VALUE, -32'd123, 1'b1, 40'h00_0000_0123);
		// zero length acts as one byte
		add_row(ROW_LEN, 32'd0, 1'b0, '0);
		add_row(ROW_VALUE, 32'd4567, 1'b1, 40'h00_0000_4567);
		// above the maximum saturates
		add_row(ROW_LEN, 32'hffff_fff7, 1'b0, '0);
		add_row(ROW_VALUE, 32'h5555_5555, 1'b0, '0);
		add_row(ROW_MODE, 32'hffff_fffe, 1'b0, '0);
		add_row(ROW_MODE, 32'd1, 1'b0, '0);
		add_row(ROW_LEN, 32'd3, 1'b0, '0);
		add_row(ROW_VALUE, -32'd999999, 1'b1, 40'h00_0999_999d);
		add_row(ROW_VALUE, 32'haaaa_aaaa, 1'b0, '0);
		add_row(ROW_LEN, 32'd2, 1'b0, '0);
		add_row(ROW_VALUE, 32'd7, 1'b1, 40'h00_0000_0070);
		add_row(ROW_LEN, 32'd6, 1'b0, '0);
		add_row(ROW_VALUE, 32'haaaa_aaab, 1'b0, '0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_MODE: begin
					drain();
					apb_write(ADDR_SIGNED_MODE, dir_rows[i].data);
				end
				ROW_LEN: begin
					drain();
					apb_write(ADDR_LENGTH_BYTES, dir_rows[i].data);
				end
				default: begin
					send_value(dir_rows[i].data, dir_rows[i].has_image, dir_rows[i].image);
				end
			endcase
		end

		for (int p = 0; p < 4; p++) begin
			for (int s = 0; s < 2; s++) begin
				drain();
				send_idle_pct = idle_plan[p];
				recv_stall_pct = stall_plan[p];
				apb_write(ADDR_SIGNED_MODE, 32'(p[0] ^ s[0]));
				if (s == 0)
					apb_write(ADDR_LENGTH_BYTES, p[0] ? 32'd1 : 32'd5);
				else
					apb_write(ADDR_LENGTH_BYTES, $urandom_range(0, 7));
				for (int k = 0; k < ITEMS_PER_SETTING; k++)
					send_value(rand_value(), 1'b0, '0);
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && pending_bytes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
